@@ src/assert_macros.svh @@
// Assertion macros shared by the column encoder modules.
// No dependencies; included by the files that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition a implies condition b in the same cycle.
`define ASSERT_IMPL(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("assertion failed: same-cycle implication");

// Condition a implies condition b in the following cycle.
`define ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("assertion failed: next-cycle implication");

`endif

@@ src/hec_pkg.sv @@
// Package for the shortened Hamming (87,80) column encoder.
// Holds widths, item types and the constant per-slot code mask table.
`default_nettype none

package hec_pkg;

    localparam int CODE_BITS          = 87;
    localparam int DATA_BITS          = 80;
    localparam int BYTE_BITS          = 8;
    localparam int SLOT_CNT_W         = 4;
    localparam int MAX_SLOTS          = 128;
    localparam int DEF_BYTES_PER_WORD = 10;
    localparam int SYN_W              = 7;

    typedef logic [CODE_BITS-1:0] t_code;

    typedef struct packed {
        logic [BYTE_BITS-1:0] data_byte;
        logic                 past_end;
    } t_in_item;

    typedef logic [MAX_SLOTS-1:0][CODE_BITS-1:0] t_mask_tbl;

    // Each data bit slot maps to a mask holding its own Hamming position
    // and every parity position that covers it. Slots past position 87 stay zero.
    function automatic t_mask_tbl build_mask_table();
        t_mask_tbl tbl;
        int        n;
        tbl = '0;
        n   = 0;
        for (int pos = 3; pos < 256; pos++) begin
            if ((pos & (pos - 1)) != 0) begin
                if (n < MAX_SLOTS && pos <= CODE_BITS) begin
                    tbl[n][pos-1] = 1'b1;
                    for (int m = 1; m <= 64; m = m * 2) begin
                        if ((pos & m) != 0) begin
                            tbl[n][m-1] = 1'b1;
                        end
                    end
                end
                n++;
            end
        end
        return tbl;
    endfunction

    localparam t_mask_tbl MASK_TABLE = build_mask_table();

    // Syndrome of a partial codeword; zero whenever the parity bits agree.
    function automatic logic [SYN_W-1:0] syndrome(input t_code w);
        logic [SYN_W-1:0] s;
        s = '0;
        for (int k = 0; k < CODE_BITS; k++) begin
            if (w[k]) begin
                s = s ^ SYN_W'(k + 1);
            end
        end
        return s;
    endfunction

endpackage

`default_nettype wire

@@ src/hec_if.sv @@
// Handshake channel interfaces for the column encoder.
// Depends on hec_pkg for field widths.
`default_nettype none

interface hec_in_if
    import hec_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [BYTE_BITS-1:0] data_byte;
    logic                 past_end;

    modport source (output valid, output data_byte, output past_end, input ready);
    modport sink   (input valid, input data_byte, input past_end, output ready);
endinterface

interface hec_out_if
    import hec_pkg::*;
();
    logic        valid;
    logic        ready;
    logic [63:0] code_low;
    logic [23:0] code_high;

    modport source (output valid, output code_low, output code_high, input ready);
    modport sink   (input valid, input code_low, input code_high, output ready);
endinterface

`default_nettype wire

@@ src/hec_in_stage.sv @@
// Input register of the column encoder: captures one byte item per cycle unless the accumulator stalls.
// Depends on hec_pkg and hec_in_if.
`default_nettype none

module hec_in_stage
    import hec_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    hec_in_if.sink    i_in,
    input  wire logic i_ready,
    output logic      o_valid,
    output t_in_item  o_item
);

    logic     r_valid;
    logic     n_valid;
    t_in_item r_item;
    logic     take;

    assign i_in.ready = !r_valid || i_ready;
    assign take       = i_in.valid && i_in.ready;

    always_comb begin
        n_valid = r_valid;
        if (take) begin
            n_valid = 1'b1;
        end else if (i_ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_item <= '{data_byte: i_in.data_byte, past_end: i_in.past_end};
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

`default_nettype wire

@@ src/hec_accum.sv @@
// Codeword accumulator: XORs each byte's slot masks into the running word.
// Depends on hec_pkg for the mask table; uses assert_macros.svh.
`default_nettype none

module hec_accum
    import hec_pkg::*;
#(
    parameter int BYTES_PER_WORD = DEF_BYTES_PER_WORD
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_valid,
    input  wire t_in_item i_item,
    input  wire logic     i_out_free,
    output logic          o_ready,
    output logic          o_push,
    output t_code         o_word,
    output logic          o_flag
);

    localparam int CNT_W = (BYTES_PER_WORD > 1) ? $clog2(BYTES_PER_WORD) : 1;

    logic [CNT_W-1:0]     r_count;
    logic [CNT_W-1:0]     n_count;
    t_code                r_acc;
    t_code                n_acc;
    logic                 r_flag;
    logic                 n_flag;
    t_code                contrib;
    logic [BYTE_BITS-1:0] eff_byte;
    logic                 last;
    logic                 advance;

    // A past-end slot contributes nothing but still counts toward the word.
    assign eff_byte = i_item.past_end ? '0 : i_item.data_byte;

    always_comb begin
        contrib = '0;
        for (int b = 0; b < BYTE_BITS; b++) begin
            if (eff_byte[b]) begin
                contrib = contrib ^ MASK_TABLE[{SLOT_CNT_W'(r_count), 3'(b)}];
            end
        end
    end

    assign last    = (r_count == CNT_W'(BYTES_PER_WORD - 1));
    assign o_ready = !last || i_out_free;
    assign advance = i_valid && o_ready;
    assign o_push  = advance && last;
    assign o_word  = r_acc ^ contrib;
    assign o_flag  = r_flag || i_item.past_end;

    always_comb begin
        n_count = r_count;
        n_acc   = r_acc;
        n_flag  = r_flag;
        if (advance) begin
            if (last) begin
                n_count = '0;
                n_acc   = '0;
                n_flag  = 1'b0;
            end else begin
                n_count = r_count + CNT_W'(1);
                n_acc   = o_word;
                n_flag  = o_flag;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_acc   <= '0;
            r_flag  <= 1'b0;
        end else begin
            r_count <= n_count;
            r_acc   <= n_acc;
            r_flag  <= n_flag;
        end
    end

`include "assert_macros.svh"

    `ASSERT_IMPL(a_count_range, i_clk, i_rst_n, 1'b1, r_count <= CNT_W'(BYTES_PER_WORD - 1))
    `ASSERT_IMPL(a_partial_syndrome, i_clk, i_rst_n, 1'b1, syndrome(r_acc) == '0)
    `ASSERT_NEXT(a_word_restart, i_clk, i_rst_n, o_push, r_count == '0 && r_acc == '0 && !r_flag)

endmodule

`default_nettype wire

@@ src/hec_out_stage.sv @@
// Result register of the column encoder: holds one finished word until taken.
// Depends on hec_pkg and hec_out_if; uses assert_macros.svh.
`default_nettype none

module hec_out_stage
    import hec_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_push,
    input  wire t_code i_word,
    input  wire logic  i_flag,
    output logic       o_free,
    hec_out_if.source  o_out
);

    logic  r_valid;
    logic  n_valid;
    t_code r_word;
    logic  r_flag;

    assign o_free = !r_valid || o_out.ready;

    always_comb begin
        n_valid = r_valid;
        if (i_push) begin
            n_valid = 1'b1;
        end else if (o_out.ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_word <= i_word;
            r_flag <= i_flag;
        end
    end

    assign o_out.valid     = r_valid;
    assign o_out.code_low  = r_word[63:0];
    assign o_out.code_high = {r_flag, r_word[CODE_BITS-1:64]};

`include "assert_macros.svh"

    `ASSERT_NEXT(a_push_held, i_clk, i_rst_n, i_push, r_valid)

endmodule

`default_nettype wire

@@ src/hamming_87_80_column_encoder_top.sv @@
// Top level of the shortened Hamming (87,80) column encoder.
// Depends on hec_pkg, hec_if, hec_in_stage, hec_accum and hec_out_stage.
//
//  channel  | direction | payload                       | per item
//  ---------+-----------+-------------------------------+---------------------------
//  i_in     | in        | data_byte[7:0], past_end      | one byte of a word
//  o_out    | out       | code_low[63:0], code_high[23:0] | one finished 88-bit word
//
// One byte item is accepted every cycle unless a stalled output holds it back; a word needs BYTES_PER_WORD items.
// The last byte of a word passes the input register, then the accumulator, which pushes
// the finished word into the result register that drives o_out.
// Reset clears the valid bits, the byte count, the running word and the flag.
// A stalled output only holds back the last byte of the following word.
`default_nettype none

module hamming_87_80_column_encoder_top
    import hec_pkg::*;
#(
    parameter int BYTES_PER_WORD = DEF_BYTES_PER_WORD
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    hec_in_if.sink    i_in,
    hec_out_if.source o_out
);

    logic     s1_valid;
    t_in_item s1_item;
    logic     acc_ready;
    logic     push;
    t_code    word;
    logic     flag;
    logic     out_free;

    hec_in_stage u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_ready (acc_ready),
        .o_valid (s1_valid),
        .o_item  (s1_item)
    );

    hec_accum #(
        .BYTES_PER_WORD (BYTES_PER_WORD)
    ) u_accum (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (s1_valid),
        .i_item     (s1_item),
        .i_out_free (out_free),
        .o_ready    (acc_ready),
        .o_push     (push),
        .o_word     (word),
        .o_flag     (flag)
    );

    hec_out_stage u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_word  (word),
        .i_flag  (flag),
        .o_free  (out_free),
        .o_out   (o_out)
    );

endmodule

`default_nettype wire
